// ===== hdl/mvsm_pkg.sv =====
// Package for the wavetable voice mixer: sizes, function codes, register selects,
// sequencer states and helper types. No dependencies.
package mvsm_pkg;
	localparam int VOICES = 64;
	localparam int SAMPLE_WORDS = 65536;
	localparam int CATEGORIES = 8;
	localparam int VW = $clog2(VOICES);
	localparam int AW = $clog2(SAMPLE_WORDS);
	localparam int CW = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1;

	typedef enum logic [1:0] {
		FUNC_MIX = 2'd0,
		FUNC_VOICE = 2'd1,
		FUNC_MEM = 2'd2,
		FUNC_CAT = 2'd3
	} func_t;

	localparam logic [3:0] SEL_START = 4'd0;
	localparam logic [3:0] SEL_LENGTH = 4'd1;
	localparam logic [3:0] SEL_FLAGS = 4'd2;
	localparam logic [3:0] SEL_GAIN = 4'd3;
	localparam logic [3:0] SEL_PAN = 4'd4;
	localparam logic [3:0] SEL_STEP = 4'd5;
	localparam logic [3:0] SEL_POS = 4'd6;
	localparam logic [3:0] SEL_CTRL = 4'd7;
	localparam logic [3:0] SEL_FADE = 4'd8;

	localparam logic CFG_MASTER = 1'b0;
	localparam logic CFG_STEREO = 1'b1;

	// per-voice sequence: read params, compute gain, fetch samples, multiply, accumulate
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_CHK,
		ST_G1,
		ST_G2,
		ST_SL,
		ST_SR,
		ST_ML,
		ST_MR,
		ST_WB,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [15:0] start;
		logic [15:0] length;
		logic [4:0] flags;
		logic [15:0] gain;
		logic [15:0] pan;
		logic [31:0] step;
		logic [31:0] pos;
		logic [15:0] fade;
	} vparam_t;

	function automatic logic signed [15:0] sat16(input logic signed [63:0] acc);
		logic signed [63:0] q;
		q = (acc < 0) ? -((-acc) >>> 30) : (acc >>> 30);
		if (q > 64'sd32767) return 16'sh7fff;
		if (q < -64'sd32768) return 16'sh8000;
		return q[15:0];
	endfunction
endpackage

// ===== hdl/mvsm_if.sv =====
// Valid/ready channel interfaces for the voice mixer.
// No dependencies.
interface mvsm_in_if;
	logic valid;
	logic ready;
	logic [1:0] func;
	logic [5:0] voice;
	logic [3:0] reg_sel;
	logic [31:0] wdata;
	logic [15:0] mem_addr;
	logic signed [15:0] mem_data;
	logic [2:0] cat_index;
	modport source(output valid, func, voice, reg_sel, wdata, mem_addr, mem_data, cat_index,
		input ready);
	modport sink(input valid, func, voice, reg_sel, wdata, mem_addr, mem_data, cat_index,
		output ready);
endinterface

interface mvsm_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] left_out;
	logic signed [15:0] right_out;
	logic [6:0] active_voices;
	modport source(output valid, left_out, right_out, active_voices, input ready);
	modport sink(input valid, left_out, right_out, active_voices, output ready);
endinterface

// ===== hdl/multi_voice_sample_mixer.sv =====
// Top level of the wavetable voice mixer: voice register files, sample memory and the
// mix sequencer. Depends on mvsm_pkg, mvsm_if and mvsm_mul.
// Register, memory and category write items are applied when taken. A mix item walks
// all 64 voices one after another through a single shared 18x18 multiplier: a skipped or
// ended voice passes ST_RD, ST_CHK and ST_WB; a playing voice takes two gain products, two
// sample reads from the one memory port, a pan product per side, then each pan-scaled
// sample times the combined gain in one 32x19 product, left then right, and write back;
// ST_RD and ST_OUT then form the frame. The frame waits in an output register until taken;
// input is accepted again once it has gone. After reset a pass clears the voice registers
// one entry at a time, and input is not ready until it ends. Sample memory has no reset.
module multi_voice_sample_mixer (
	input logic clk,
	input logic arst_n,
	mvsm_in_if.sink in_ch,
	mvsm_out_if.source out_ch,
	input logic cfg_we,
	input logic cfg_index,
	input logic [15:0] cfg_wdata
);
	import mvsm_pkg::*;

	logic [15:0] master_q;
	logic stereo_q;
	logic [VOICES-1:0] act_q, play_q, stop_q;
	logic [15:0] start_m [VOICES];
	logic [15:0] len_m [VOICES];
	logic [4:0] flags_m [VOICES];
	logic [15:0] gain_m [VOICES];
	logic [15:0] pan_m [VOICES];
	logic [31:0] step_m [VOICES];
	logic [31:0] pos_m [VOICES];
	logic [15:0] fade_m [VOICES];
	logic [15:0] catg_q [CATEGORIES];
	logic [15:0] smem [SAMPLE_WORDS];

	state_t st_q, st_d;
	logic [VW:0] vi_q;
	logic [VW:0] clr_q;
	logic [VW-1:0] vix;
	vparam_t vp_q;
	logic [17:0] g_q;
	logic signed [15:0] sl_q, sr_q, rd_q;
	logic signed [63:0] accl_q, accr_q;
	logic [AW-1:0] raddr;
	logic out_v_q;

	logic signed [17:0] ma, mb;
	logic signed [35:0] p_q;
	mvsm_mul u_mul (.clk(clk), .a(ma), .b(mb), .p_q(p_q));

	assign vix = vi_q[VW-1:0];
	assign in_ch.ready = (st_q == ST_IDLE) && !out_v_q && clr_q[VW];
	wire take = in_ch.valid && in_ch.ready;
	wire [15:0] idx = vp_q.pos[31:16];
	wire [CW-1:0] cat = vp_q.flags[2+:CW];
	wire signed [16:0] pan_s = {vp_q.pan[15], vp_q.pan};
	wire signed [17:0] pl = (stereo_q && !pan_s[16] && pan_s != 0) ?
		18'sd32768 - 18'(pan_s) : 18'sd32768;
	wire signed [17:0] pr = (stereo_q && pan_s[16]) ? 18'sd32768 + 18'(pan_s) : 18'sd32768;
	wire [AW-1:0] base = AW'(vp_q.start) + (vp_q.flags[1] ? AW'({idx, 1'b0}) : AW'(idx));

	always_ff @(posedge clk) begin
		rd_q <= smem[raddr];
		if (take && in_ch.func == FUNC_MEM) smem[in_ch.mem_addr[AW-1:0]] <= in_ch.mem_data;
	end

	always_comb begin
		st_d = st_q;
		ma = '0;
		mb = '0;
		raddr = base;
		case (st_q)
			ST_IDLE: if (take && in_ch.func == FUNC_MIX) st_d = ST_RD;
			ST_RD: st_d = (vi_q == (VW+1)'(VOICES)) ? ST_OUT : ST_CHK;
			ST_CHK: begin
				if (!act_q[vix] || !play_q[vix] || idx >= vp_q.length) st_d = ST_WB;
				else st_d = ST_G1;
				ma = 18'({2'b0, master_q});
				mb = 18'({2'b0, vp_q.gain});
			end
			ST_G1: begin
				st_d = ST_G2;
				ma = 18'(p_q[35:15]);
				mb = 18'({2'b0, catg_q[cat]});
			end
			ST_G2: begin
				st_d = ST_SL;
				raddr = base;
			end
			ST_SL: begin
				st_d = ST_SR;
				raddr = base + AW'(1);
			end
			ST_SR: begin
				st_d = ST_ML;
				ma = 18'(sl_q);
				mb = pl;
			end
			ST_ML: begin
				st_d = ST_MR;
				ma = 18'(vp_q.flags[1] ? sr_q : sl_q);
				mb = pr;
			end
			ST_MR: st_d = ST_WB;
			ST_WB: st_d = ST_RD;
			ST_OUT: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// pan products fit 31 bits; they are scaled by the combined gain below
	logic signed [31:0] ml_q, mr_q;
	logic playing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			vi_q <= '0;
			clr_q <= '0;
			out_v_q <= 1'b0;
			playing_q <= 1'b0;
			master_q <= 16'd32768;
			stereo_q <= 1'b1;
			act_q <= '0;
			play_q <= '0;
			stop_q <= '0;
			for (int i = 0; i < CATEGORIES; i++) catg_q[i] <= 16'd32768;
		end else begin
			st_q <= st_d;
			if (!clr_q[VW]) clr_q <= clr_q + 1'b1;
			if (cfg_we) begin
				if (cfg_index == CFG_MASTER) master_q <= cfg_wdata;
				else stereo_q <= cfg_wdata[0];
			end
			if (out_ch.valid && out_ch.ready) out_v_q <= 1'b0;
			if (take) begin
				case (func_t'(in_ch.func))
					FUNC_VOICE: begin
						if (in_ch.reg_sel == SEL_CTRL) begin
							act_q[in_ch.voice] <= in_ch.wdata[0];
							play_q[in_ch.voice] <= in_ch.wdata[1];
							stop_q[in_ch.voice] <= in_ch.wdata[2];
						end
					end
					FUNC_CAT: catg_q[in_ch.cat_index[CW-1:0]] <= in_ch.wdata[15:0];
					FUNC_MIX: vi_q <= '0;
					default: ;
				endcase
			end
			case (st_q)
				ST_CHK: playing_q <= act_q[vix] && play_q[vix] && idx < vp_q.length;
				ST_WB: begin
					vi_q <= vi_q + 1'b1;
					if (playing_q) begin
						if (stop_q[vix] && vp_q.gain <= vp_q.fade) act_q[vix] <= 1'b0;
					end else if (act_q[vix] && play_q[vix] && !vp_q.flags[0]) begin
						act_q[vix] <= 1'b0;
					end
				end
				ST_OUT: out_v_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// voice register files: cleared one entry at a time after reset, then written by
	// register items and by the write back of each mixed voice
	always_ff @(posedge clk) begin
		if (!clr_q[VW]) begin
			start_m[clr_q[VW-1:0]] <= '0; len_m[clr_q[VW-1:0]] <= '0;
			flags_m[clr_q[VW-1:0]] <= '0; gain_m[clr_q[VW-1:0]] <= '0;
			pan_m[clr_q[VW-1:0]] <= '0; step_m[clr_q[VW-1:0]] <= '0;
			pos_m[clr_q[VW-1:0]] <= '0; fade_m[clr_q[VW-1:0]] <= '0;
		end else if (take && in_ch.func == FUNC_VOICE) begin
			case (in_ch.reg_sel)
				SEL_START: start_m[in_ch.voice] <= in_ch.wdata[15:0];
				SEL_LENGTH: len_m[in_ch.voice] <= in_ch.wdata[15:0];
				SEL_FLAGS: flags_m[in_ch.voice] <= in_ch.wdata[4:0];
				SEL_GAIN: gain_m[in_ch.voice] <= in_ch.wdata[15:0];
				SEL_PAN: pan_m[in_ch.voice] <= in_ch.wdata[15:0];
				SEL_STEP: step_m[in_ch.voice] <= in_ch.wdata;
				SEL_POS: pos_m[in_ch.voice] <= in_ch.wdata;
				SEL_FADE: fade_m[in_ch.voice] <= in_ch.wdata[15:0];
				default: ;
			endcase
		end else if (st_q == ST_WB && playing_q) begin
			pos_m[vix] <= (vp_q.pos > ~vp_q.step) ? 32'hffff_ffff : vp_q.pos + vp_q.step;
			if (stop_q[vix])
				gain_m[vix] <= (vp_q.gain <= vp_q.fade) ? 16'd0 : vp_q.gain - vp_q.fade;
		end else if (st_q == ST_WB && act_q[vix] && play_q[vix] && vp_q.flags[0]) begin
			pos_m[vix] <= '0;
		end
	end

	// accumulate: pan product (<=2^30) times combined gain (<2^18), left in ST_MR,
	// right in ST_WB
	logic signed [18:0] gs;
	logic signed [31:0] wm;
	logic signed [50:0] tw;
	always_comb begin
		gs = {1'b0, g_q};
		wm = (st_q == ST_MR) ? ml_q : mr_q;
		tw = wm * gs;
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_RD) begin
			vp_q.start <= start_m[vix]; vp_q.length <= len_m[vix];
			vp_q.flags <= flags_m[vix]; vp_q.gain <= gain_m[vix];
			vp_q.pan <= pan_m[vix]; vp_q.step <= step_m[vix];
			vp_q.pos <= pos_m[vix]; vp_q.fade <= fade_m[vix];
		end
		if (st_q == ST_G2) g_q <= p_q[32:15];
		if (st_q == ST_SL) sl_q <= rd_q;
		if (st_q == ST_SR) sr_q <= rd_q;
		if (st_q == ST_ML) ml_q <= p_q[31:0];
		if (st_q == ST_MR) mr_q <= p_q[31:0];
		if (take && in_ch.func == FUNC_MIX) begin
			accl_q <= '0;
			accr_q <= '0;
		end
		if (st_q == ST_MR) accl_q <= accl_q + 64'(tw);
		if (st_q == ST_WB && playing_q && stereo_q) accr_q <= accr_q + 64'(tw);
		if (st_q == ST_OUT) begin
			out_ch.left_out <= sat16(accl_q);
			out_ch.right_out <= stereo_q ? sat16(accr_q) : 16'sd0;
			out_ch.active_voices <= 7'($countones(act_q));
		end
	end
	assign out_ch.valid = out_v_q;

`ifndef SYNTHESIS
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !in_ch.ready) else $error("ready while mixing");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUT) |=> out_v_q) else $error("frame lost");
`endif
endmodule

// ===== hdl/mvsm_mul.sv =====
// Shared signed multiplier with registered product, used by the mix sequencer.
// No dependencies.
module mvsm_mul (
	input logic clk,
	input logic signed [17:0] a,
	input logic signed [17:0] b,
	output logic signed [35:0] p_q
);
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for multi_voice_sample_mixer: directed table, then random
// voice programming, memory, category and mix items. Depends on mvsm_pkg and mvsm_if.
module tb;
	import mvsm_pkg::*;

	localparam logic [3:0] SEL_NONE = 4'd15; // decoded as no register, write ignored

	typedef struct {
		func_t func;
		logic [5:0] voice;
		logic [3:0] reg_sel;
		logic [31:0] wdata;
		logic [15:0] mem_addr;
		logic signed [15:0] mem_data;
		logic [2:0] cat_index;
	} mix_cmd_t;

	typedef struct {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic [6:0] count;
	} frame_t;

	typedef struct {
		mix_cmd_t cmd;
		bit typed;
		frame_t frame;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_MASTER;
	logic [15:0] cfg_wdata = '0;

	mvsm_in_if in_ch();
	mvsm_out_if out_ch();

	multi_voice_sample_mixer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// mirror of the block's state
	logic [15:0] smem [0:SAMPLE_WORDS-1];
	bit smem_written [0:SAMPLE_WORDS-1];
	bit v_active [0:VOICES-1];
	bit v_playing [0:VOICES-1];
	bit v_stopping [0:VOICES-1];
	logic [4:0] v_flags [0:VOICES-1];
	logic [15:0] v_start [0:VOICES-1];
	logic [15:0] v_len [0:VOICES-1];
	logic [15:0] v_gain [0:VOICES-1];
	logic [15:0] v_pan [0:VOICES-1];
	logic [31:0] v_step [0:VOICES-1];
	logic [31:0] v_pos [0:VOICES-1];
	logic [15:0] v_fade [0:VOICES-1];
	logic [15:0] cat_gain [0:CATEGORIES-1];
	logic [15:0] master;
	bit stereo;

	frame_t frame_q[$];
	int errors = 0;
	bit no_stall = 1'b0;

	initial begin
		for (int i = 0; i < VOICES; i++) begin
			v_active[i] = 0; v_playing[i] = 0; v_stopping[i] = 0; v_flags[i] = '0;
			v_start[i] = '0; v_len[i] = '0; v_gain[i] = '0; v_pan[i] = '0;
			v_step[i] = '0; v_pos[i] = '0; v_fade[i] = '0;
		end
		for (int i = 0; i < CATEGORIES; i++) cat_gain[i] = 16'd32768;
		for (int i = 0; i < SAMPLE_WORDS; i++) smem_written[i] = 0;
		master = 16'd32768;
		stereo = 1'b1;
	end

	function automatic logic signed [15:0] clip16(longint acc);
		longint q;
		q = acc / (longint'(1) << 30);
		if (q > 32767) return 16'sh7fff;
		if (q < -32768) return 16'sh8000;
		return q[15:0];
	endfunction

	function automatic longint rd_sample(logic [15:0] addr);
		return longint'($signed(smem[addr]));
	endfunction

	task automatic mix_frame(output frame_t f);
		longint accl, accr, g, pl, pr, sl, sr, pan;
		logic [31:0] idx;
		logic [15:0] addr;
		int cnt;
		accl = 0; accr = 0; cnt = 0;
		for (int i = 0; i < VOICES; i++) begin
			if (!v_active[i] || !v_playing[i]) continue;
			idx = v_pos[i] >> 16;
			if (idx >= v_len[i]) begin
				if (v_flags[i][0]) v_pos[i] = '0;
				else v_active[i] = 0;
				continue;
			end
			g = (longint'(master) * longint'(v_gain[i])) >>> 15;
			g = (g * longint'(cat_gain[v_flags[i][4:2] % CATEGORIES])) >>> 15;
			if (v_flags[i][1]) begin
				addr = v_start[i] + 16'(2 * idx);
				sl = rd_sample(addr);
				sr = rd_sample(addr + 16'd1);
			end else begin
				addr = v_start[i] + idx[15:0];
				sl = rd_sample(addr);
				sr = sl;
			end
			pl = 32768; pr = 32768;
			if (stereo) begin
				pan = longint'($signed(v_pan[i]));
				if (pan > 0) pl = 32768 - pan;
				else if (pan < 0) pr = 32768 + pan;
				accr += sr * pr * g;
			end
			accl += sl * pl * g;
			if (v_pos[i] > 32'hFFFF_FFFF - v_step[i]) v_pos[i] = 32'hFFFF_FFFF;
			else v_pos[i] = v_pos[i] + v_step[i];
			if (v_stopping[i]) begin
				if (v_gain[i] <= v_fade[i]) begin
					v_gain[i] = '0;
					v_active[i] = 0;
				end else begin
					v_gain[i] = v_gain[i] - v_fade[i];
				end
			end
		end
		for (int i = 0; i < VOICES; i++) if (v_active[i]) cnt++;
		f.left = clip16(accl);
		f.right = stereo ? clip16(accr) : 16'sd0;
		f.count = 7'(cnt);
	endtask

	// applies one accepted item to the mirror, returns 1 with a frame for a mix
	task automatic apply_item(input mix_cmd_t c, output bit has_frame, output frame_t f);
		has_frame = 0;
		f = '{default: '0};
		case (c.func)
			FUNC_VOICE: begin
				case (c.reg_sel)
					SEL_START: v_start[c.voice] = c.wdata[15:0];
					SEL_LENGTH: v_len[c.voice] = c.wdata[15:0];
					SEL_FLAGS: v_flags[c.voice] = c.wdata[4:0];
					SEL_GAIN: v_gain[c.voice] = c.wdata[15:0];
					SEL_PAN: v_pan[c.voice] = c.wdata[15:0];
					SEL_STEP: v_step[c.voice] = c.wdata;
					SEL_POS: v_pos[c.voice] = c.wdata;
					SEL_CTRL: begin
						v_active[c.voice] = c.wdata[0];
						v_playing[c.voice] = c.wdata[1];
						v_stopping[c.voice] = c.wdata[2];
					end
					SEL_FADE: v_fade[c.voice] = c.wdata[15:0];
					default: ;
				endcase
			end
			FUNC_MEM: begin
				smem[c.mem_addr] = c.mem_data;
				smem_written[c.mem_addr] = 1;
			end
			FUNC_CAT: cat_gain[c.cat_index] = c.wdata[15:0];
			default: begin
				mix_frame(f);
				has_frame = 1;
			end
		endcase
	endtask

	// every sample word that the voice could read is already written
	function automatic bit reads_written(bit act, logic [15:0] start, logic [15:0] len,
			logic [4:0] flags, logic [31:0] pos);
		int first;
		logic [15:0] a;
		if (!act || len == 0) return 1;
		first = flags[0] ? 0 : int'(pos >> 16);
		if (first >= len) first = flags[0] ? 0 : int'(len);
		if (first >= len) return 1;
		if (int'(len) - first > 300) return 0;
		for (int k = first; k < len; k++) begin
			a = flags[1] ? start + 16'(2 * k) : start + 16'(k);
			if (!smem_written[a]) return 0;
			if (flags[1] && !smem_written[a + 16'd1]) return 0;
		end
		return 1;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_stall) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	task automatic send_item(input mix_cmd_t c, input bit typed, input frame_t tf);
		bit hf;
		frame_t f;
		repeat (pick_gap()) @(negedge clk);
		in_ch.valid = 1'b1;
		in_ch.func = c.func;
		in_ch.voice = c.voice;
		in_ch.reg_sel = c.reg_sel;
		in_ch.wdata = c.wdata;
		in_ch.mem_addr = c.mem_addr;
		in_ch.mem_data = c.mem_data;
		in_ch.cat_index = c.cat_index;
		do @(posedge clk); while (!in_ch.ready);
		apply_item(c, hf, f);
		if (hf) frame_q.push_back(typed ? tf : f);
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	function automatic mix_cmd_t blank_cmd(func_t fn);
		mix_cmd_t c;
		c.func = fn;
		c.voice = 6'($urandom);
		c.reg_sel = 4'($urandom);
		c.wdata = $urandom;
		c.mem_addr = 16'($urandom);
		c.mem_data = 16'($urandom);
		c.cat_index = 3'($urandom);
		return c;
	endfunction

	function automatic mix_cmd_t vcmd(int v, logic [3:0] sel, logic [31:0] w);
		mix_cmd_t c;
		c = blank_cmd(FUNC_VOICE);
		c.voice = 6'(v);
		c.reg_sel = sel;
		c.wdata = w;
		return c;
	endfunction

	// voice write with a guard against reads of unwritten sample words
	task automatic voice_wr(int v, logic [3:0] sel, logic [31:0] w);
		bit act;
		logic [15:0] st, ln;
		logic [4:0] fl;
		logic [31:0] ps;
		mix_cmd_t c;
		frame_t nf;
		act = v_active[v]; st = v_start[v]; ln = v_len[v]; fl = v_flags[v]; ps = v_pos[v];
		case (sel)
			SEL_START: st = w[15:0];
			SEL_LENGTH: ln = w[15:0];
			SEL_FLAGS: fl = w[4:0];
			SEL_POS: ps = w;
			SEL_CTRL: act = w[0];
			default: ;
		endcase
		c = vcmd(v, sel, w);
		if (!reads_written(act, st, ln, fl, ps)) c.reg_sel = SEL_NONE;
		nf = '{default: '0};
		send_item(c, 0, nf);
	endtask

	task automatic cfg_write(logic idx, logic [15:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_MASTER) master = val;
		else stereo = val[0];
	endtask

	task automatic settle();
		wait (frame_q.size() == 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic program_voice();
		int v, r;
		logic [15:0] st, ln;
		logic [31:0] ctl;
		v = $urandom_range(0, VOICES - 1);
		ln = 16'($urandom_range(0, 40));
		st = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 40))
			: 16'($urandom_range(65500, 65535));
		voice_wr(v, SEL_CTRL, 32'd0);
		voice_wr(v, SEL_START, {16'($urandom), st});
		voice_wr(v, SEL_LENGTH, {16'($urandom), ln});
		voice_wr(v, SEL_FLAGS, $urandom);
		voice_wr(v, SEL_GAIN, $urandom);
		voice_wr(v, SEL_PAN, $urandom);
		voice_wr(v, SEL_STEP, {14'd0, 18'($urandom)});
		r = $urandom_range(0, 9);
		voice_wr(v, SEL_POS, (r < 6) ? 32'd0 : (r < 9) ? $urandom_range(0, ln * 65536)
			: $urandom);
		voice_wr(v, SEL_FADE, {16'($urandom), 16'($urandom_range(0, 4000))});
		r = $urandom_range(0, 9);
		ctl = (r < 6) ? 32'd3 : (r < 8) ? 32'd7 : $urandom;
		voice_wr(v, SEL_CTRL, ctl);
	endtask

	// output side: random stalls, checks each frame against the oldest expectation
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready = (no_stall || $urandom_range(0, 99) < 70) ? 1'b1 : 1'b0;
			if (!out_ch.ready && !no_stall && $urandom_range(0, 19) == 0)
				repeat ($urandom_range(10, 60)) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		frame_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (frame_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected frame l=%0d r=%0d n=%0d",
					out_ch.left_out, out_ch.right_out, out_ch.active_voices);
			end else begin
				e = frame_q.pop_front();
				if (out_ch.left_out !== e.left || out_ch.right_out !== e.right ||
						out_ch.active_voices !== e.count) begin
					errors++;
					if (errors <= 10)
						$display("frame mismatch: exp l=%0d r=%0d n=%0d got l=%0d r=%0d n=%0d",
							e.left, e.right, e.count, out_ch.left_out, out_ch.right_out,
							out_ch.active_voices);
				end
			end
		end
	end

	initial begin
		#(64'd60_000_000);
		$display("multi_voice_sample_mixer verification failed");
		$finish;
	end

	initial begin
		dir_row_t rows[$];
		dir_row_t row;
		mix_cmd_t c;
		frame_t z;
		int sent, r;
		in_ch.valid = 1'b0;
		in_ch.func = FUNC_MIX;
		in_ch.voice = '0;
		in_ch.reg_sel = '0;
		in_ch.wdata = '0;
		in_ch.mem_addr = '0;
		in_ch.mem_data = '0;
		in_ch.cat_index = '0;
		z = '{default: '0};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// sample words at both ends of memory so clips can wrap
		for (int a = 0; a < 120; a++) begin
			c = blank_cmd(FUNC_MEM);
			c.mem_addr = 16'(a);
			if (a == 0) c.mem_data = 16'sh7fff;
			if (a == 1) c.mem_data = 16'sh8000;
			send_item(c, 0, z);
		end
		for (int a = 65500; a < 65536; a++) begin
			c = blank_cmd(FUNC_MEM);
			c.mem_addr = 16'(a);
			send_item(c, 0, z);
		end

		row.typed = 0; row.frame = z;
		row.cmd = blank_cmd(FUNC_MIX); row.typed = 1; rows.push_back(row); // nothing playing
		row.typed = 0;
		row.cmd = blank_cmd(FUNC_CAT); row.cmd.cat_index = 3'd7;
		row.cmd.wdata = 32'hFFFF_FFFF; rows.push_back(row);
		row.cmd = vcmd(63, SEL_CTRL, 32'd0); rows.push_back(row);
		row.cmd = vcmd(63, SEL_START, 32'hFFFF_0000); rows.push_back(row);
		row.cmd = vcmd(63, SEL_LENGTH, 32'd1); rows.push_back(row);
		row.cmd = vcmd(63, SEL_FLAGS, 32'h1F); rows.push_back(row);
		row.cmd = vcmd(63, SEL_GAIN, 32'hFFFF); rows.push_back(row);
		row.cmd = vcmd(63, SEL_PAN, 32'h8000); rows.push_back(row);
		row.cmd = vcmd(63, SEL_STEP, 32'hFFFF_FFFF); rows.push_back(row);
		row.cmd = vcmd(63, SEL_CTRL, 32'd3); rows.push_back(row);
		row.cmd = blank_cmd(FUNC_MIX); rows.push_back(row); // saturates, position pins
		row.cmd = blank_cmd(FUNC_MIX); rows.push_back(row); // past end, repeats
		// position overflow near the top of a long clip pins it; the next mix frees it at the end
		row.cmd = vcmd(0, SEL_CTRL, 32'd0); rows.push_back(row);
		row.cmd = vcmd(0, SEL_START, 32'd2); rows.push_back(row);
		row.cmd = vcmd(0, SEL_LENGTH, 32'hFFFF); rows.push_back(row);
		row.cmd = vcmd(0, SEL_POS, 32'hFFFE_FFFF); rows.push_back(row);
		row.cmd = vcmd(0, SEL_STEP, 32'h0002_0000); rows.push_back(row);
		row.cmd = vcmd(0, SEL_GAIN, 32'h4000); rows.push_back(row);
		row.cmd = vcmd(0, SEL_PAN, 32'h7FFF); rows.push_back(row);
		row.cmd = vcmd(0, SEL_FADE, 32'h3000); rows.push_back(row);
		row.cmd = vcmd(0, SEL_CTRL, 32'd7); rows.push_back(row);
		row.cmd = blank_cmd(FUNC_MIX); rows.push_back(row);
		row.cmd = blank_cmd(FUNC_MIX); rows.push_back(row);
		row.cmd = vcmd(5, SEL_NONE, 32'hFFFF_FFFF); rows.push_back(row);
		row.cmd = blank_cmd(FUNC_MEM); row.cmd.mem_addr = 16'hFFFF;
		row.cmd.mem_data = 16'sh8000; rows.push_back(row);
		foreach (rows[i]) send_item(rows[i].cmd, rows[i].typed, rows[i].frame);

		sent = 0;
		for (int ph = 0; ph < 6; ph++) begin
			settle();
			case (ph)
				0: begin cfg_write(CFG_MASTER, 16'hFFFF); cfg_write(CFG_STEREO, 16'h0001); end
				1: begin cfg_write(CFG_STEREO, 16'hFFFE); end
				2: begin cfg_write(CFG_MASTER, 16'h0000); cfg_write(CFG_STEREO, 16'h0001); end
				default: begin
					cfg_write(CFG_MASTER, 16'($urandom));
					cfg_write(CFG_STEREO, 16'($urandom));
				end
			endcase
			no_stall = (ph == 3);
			while (sent < (ph + 1) * 62) begin
				r = $urandom_range(0, 99);
				if (r < 35) begin
					send_item(blank_cmd(FUNC_MIX), 0, z);
					sent++;
				end else if (r < 65) begin
					program_voice();
					sent += 10;
				end else if (r < 80) begin
					voice_wr($urandom_range(0, VOICES - 1), 4'($urandom), $urandom);
					sent++;
				end else if (r < 90) begin
					send_item(blank_cmd(FUNC_MEM), 0, z);
					sent++;
				end else begin
					c = blank_cmd(FUNC_CAT);
					if ($urandom_range(0, 3) == 0) c.wdata[15:0] = 16'd32768;
					send_item(c, 0, z);
					sent++;
				end
			end
		end
		no_stall = 1'b0;

		wait (frame_q.size() == 0);
		repeat (700) @(posedge clk);
		if (errors == 0)
			$display("multi_voice_sample_mixer verification clean");
		else
			$display("multi_voice_sample_mixer verification failed");
		$finish;
	end
endmodule
